// File: hdl/adlq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adlq_pkg
// Shared types and constants of the audio DMA length queue.
// ----------------------------------------------------------------------------
package adlq_pkg;

  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 24;
  localparam int LEN_W     = 18;
  localparam int ACC_W     = 33;
  localparam int DIVISOR_W = 16;

  // Two-entry queue between decode and execute; a power of two.
  localparam int QUEUE_DEPTH = 2;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int CYCLES_PER_SAMPLE_DEF = 2929;

  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam logic [2:0] REG_ADDR   = 3'd0;
  localparam logic [2:0] REG_LEN    = 3'd1;
  localparam logic [2:0] REG_STATUS = 3'd3;

  localparam logic [DATA_W-1:0] ADDR_MASK   = 32'h00ff_fff8;
  localparam logic [DATA_W-1:0] LEN_MASK    = 32'h0003_fff8;
  localparam logic [DATA_W-1:0] STAT_FULL   = 32'h8000_0001;
  localparam logic [DATA_W-1:0] STAT_BUSY   = 32'h4000_0000;
  localparam logic [LEN_W:0]    LEN_SPAN    = 19'h4_0000;
  localparam logic [1:0]        QUEUED_FULL = 2'd2;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_RD_LEN,
    OP_RD_STATUS,
    OP_WR_ADDR,
    OP_WR_LEN,
    OP_WR_STATUS,
    OP_TICK
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [DATA_W-1:0] data;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_WALK,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic             start;
    logic [ACC_W-1:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [ACC_W-1:0]     quotient;
    logic [DIVISOR_W-1:0] remainder;
  } div_rsp_t;

endpackage

// File: hdl/adlq_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adlq_req_if
// Request channel: register accesses and elapsed-time ticks.
// ----------------------------------------------------------------------------
interface adlq_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [2:0]  reg_index;
  logic [31:0] write_data;
  logic [31:0] tick_cycles;

  modport source (output valid, output cmd, output reg_index, output write_data,
                  output tick_cycles, input ready);
  modport sink   (input valid, input cmd, input reg_index, input write_data,
                  input tick_cycles, output ready);
endinterface

// File: hdl/adlq_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adlq_rsp_if
// Response channel: read data, interrupt level and DMA start.
// ----------------------------------------------------------------------------
interface adlq_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        irq;
  logic        dma_start;
  logic [23:0] dma_address;
  logic [17:0] dma_length;

  modport source (output valid, output read_data, output irq, output dma_start,
                  output dma_address, output dma_length, input ready);
  modport sink   (input valid, input read_data, input irq, input dma_start,
                  input dma_address, input dma_length, output ready);
endinterface

// File: hdl/adlq_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adlq_front
// Accepts request items and decodes them into queue entries.
// ----------------------------------------------------------------------------
module adlq_front (
  adlq_req_if.sink          req,
  input  logic              full,
  output logic              push,
  output adlq_pkg::entry_t  entry
);

  assign req.ready = !full;
  assign push      = req.valid && !full;

  always_comb begin
    entry.op   = adlq_pkg::OP_NOP;
    entry.data = '0;
    unique case (req.cmd)
      adlq_pkg::CMD_READ: begin
        if (req.reg_index == adlq_pkg::REG_LEN) begin
          entry.op = adlq_pkg::OP_RD_LEN;
        end else if (req.reg_index == adlq_pkg::REG_STATUS) begin
          entry.op = adlq_pkg::OP_RD_STATUS;
        end
      end
      adlq_pkg::CMD_WRITE: begin
        if (req.reg_index == adlq_pkg::REG_ADDR) begin
          entry.op   = adlq_pkg::OP_WR_ADDR;
          entry.data = req.write_data & adlq_pkg::ADDR_MASK;
        end else if (req.reg_index == adlq_pkg::REG_LEN) begin
          entry.op   = adlq_pkg::OP_WR_LEN;
          entry.data = req.write_data & adlq_pkg::LEN_MASK;
        end else if (req.reg_index == adlq_pkg::REG_STATUS) begin
          entry.op = adlq_pkg::OP_WR_STATUS;
        end
      end
      adlq_pkg::CMD_TICK: begin
        entry.op   = adlq_pkg::OP_TICK;
        entry.data = req.tick_cycles;
      end
      default: begin
        entry.op = adlq_pkg::OP_NOP;
      end
    endcase
  end

endmodule

// File: hdl/adlq_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adlq_fifo
// Short queue of decoded entries between decode and execute.
// ----------------------------------------------------------------------------
module adlq_fifo (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  adlq_pkg::entry_t              push_data,
  output logic                          full,
  input  logic                          pop,
  output logic                          pop_valid,
  output adlq_pkg::entry_t              pop_data,
  output logic [adlq_pkg::QCNT_W-1:0]   count
);

  localparam int PTR_W = (adlq_pkg::QUEUE_DEPTH > 1) ? $clog2(adlq_pkg::QUEUE_DEPTH) : 1;

  adlq_pkg::entry_t  slots [adlq_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;

  assign full      = (count == adlq_pkg::QCNT_W'(adlq_pkg::QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop && pop_valid) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !(pop && pop_valid)) begin
        count <= count + adlq_pkg::QCNT_W'(1);
      end else if (!push && pop && pop_valid) begin
        count <= count - adlq_pkg::QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// File: hdl/adlq_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adlq_div
// Divides by a fixed sample period with a scaled reciprocal: four partial
// products in four steps, then the quotient and remainder in a fifth step.
// ----------------------------------------------------------------------------
module adlq_div #(
  parameter int DIVISOR = adlq_pkg::CYCLES_PER_SAMPLE_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  adlq_pkg::div_req_t  req,
  output adlq_pkg::div_rsp_t  rsp
);

  localparam int ACC_W  = adlq_pkg::ACC_W;
  localparam int DV_W   = adlq_pkg::DIVISOR_W;
  localparam int XP_W   = (ACC_W + 1) / 2;
  localparam int MP_W   = 18;
  localparam int PP_W   = XP_W + MP_W;
  localparam int PROD_W = 2 * PP_W;
  localparam int MUL_W  = ACC_W + DV_W;
  // floor(x * RECIP / 2^SHIFT) equals floor(x / DIVISOR) for every ACC_W-bit x.
  localparam int SHIFT  = ACC_W + $clog2(DIVISOR);
  localparam logic [63:0] RECIP =
    ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [2*MP_W-1:0] RECIP_W   = (2*MP_W)'(RECIP);
  localparam logic [DV_W-1:0]   DIV_VAL   = DV_W'(DIVISOR);
  localparam logic [2:0]        LAST_STEP = 3'd4;

  logic                busy;
  logic                done;
  logic [2:0]          step;
  logic [2*XP_W-1:0]   xr;
  logic [PROD_W-1:0]   prod;
  logic [ACC_W-1:0]    quo;
  logic [DV_W-1:0]     remd;
  logic [XP_W-1:0]     x_part;
  logic [MP_W-1:0]     m_part;
  logic [PP_W-1:0]     partial;
  logic [PROD_W-1:0]   partial_sh;
  logic [ACC_W-1:0]    quo_calc;
  logic [MUL_W-1:0]    back_mul;
  logic [ACC_W-1:0]    rem_full;
  logic                finish;

  // Step 0: low x * low m, 1: low x * high m, 2: high x * low m, 3: high * high.
  assign x_part  = step[1] ? xr[2*XP_W-1:XP_W] : xr[XP_W-1:0];
  assign m_part  = step[0] ? RECIP_W[2*MP_W-1:MP_W] : RECIP_W[MP_W-1:0];
  assign partial = PP_W'(x_part) * PP_W'(m_part);

  always_comb begin
    unique case (step[1:0])
      2'd0:    partial_sh = PROD_W'(partial);
      2'd1:    partial_sh = PROD_W'(partial) << MP_W;
      2'd2:    partial_sh = PROD_W'(partial) << XP_W;
      default: partial_sh = PROD_W'(partial) << PP_W;
    endcase
  end

  assign quo_calc = ACC_W'(prod >> SHIFT);
  assign back_mul = MUL_W'(quo_calc) * MUL_W'(DIV_VAL);
  assign rem_full = xr[ACC_W-1:0] - back_mul[ACC_W-1:0];
  assign finish   = busy && !req.start && (step == LAST_STEP);

  assign rsp.busy      = busy;
  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = remd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= finish;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 3'd1;
        if (step == LAST_STEP) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      xr   <= (2*XP_W)'(req.dividend);
      prod <= '0;
    end else if (busy) begin
      if (step == LAST_STEP) begin
        quo  <= quo_calc;
        remd <= rem_full[DV_W-1:0];
      end else begin
        prod <= prod + partial_sh;
      end
    end
  end

endmodule

// File: hdl/adlq_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adlq_back
// Executes queued entries: register state, length queue and sample walk.
// ----------------------------------------------------------------------------
module adlq_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  adlq_pkg::entry_t    q_data,
  output logic                q_pop,
  output adlq_pkg::div_req_t  div_req,
  input  adlq_pkg::div_rsp_t  div_rsp,
  adlq_rsp_if.source          rsp
);

  localparam int DATA_W = adlq_pkg::DATA_W;
  localparam int ADDR_W = adlq_pkg::ADDR_W;
  localparam int LEN_W  = adlq_pkg::LEN_W;
  localparam int ACC_W  = adlq_pkg::ACC_W;
  localparam int DV_W   = adlq_pkg::DIVISOR_W;

  adlq_pkg::state_t state;
  adlq_pkg::state_t state_next;

  logic [ACC_W-1:0]  acc;
  logic [LEN_W-1:0]  cur_len;
  logic [LEN_W-1:0]  nxt_len;
  logic [1:0]        queued;
  logic [ADDR_W-1:0] dram_addr;
  logic              irq_pend;
  logic [ACC_W-1:0]  samples;
  logic [DV_W-1:0]   rem;

  logic              out_valid;
  logic [DATA_W-1:0] out_rd;
  logic              out_irq;
  logic              out_start;
  logic [ADDR_W-1:0] out_addr;
  logic [LEN_W-1:0]  out_len;

  logic              out_free;
  logic              tick_go;
  logic              emit_now;
  logic              emit_late;
  logic              walk_done;
  logic [ACC_W-1:0]  acc_sum;
  logic [LEN_W:0]    need;
  logic              short_run;

  logic [DATA_W-1:0] imm_rd;
  logic              imm_irq;
  logic              imm_start;

  assign out_free = !out_valid || rsp.ready;
  assign acc_sum  = acc + ACC_W'(q_data.data);
  // A length of zero stands for a full 2^18-sample buffer.
  assign need      = (cur_len == '0) ? adlq_pkg::LEN_SPAN : {1'b0, cur_len};
  assign short_run = (samples < ACC_W'(need));

  assign rsp.valid       = out_valid;
  assign rsp.read_data   = out_rd;
  assign rsp.irq         = out_irq;
  assign rsp.dma_start   = out_start;
  assign rsp.dma_address = out_addr;
  assign rsp.dma_length  = out_len;

  always_comb begin
    state_next = state;
    unique case (state)
      adlq_pkg::ST_IDLE: begin
        if (tick_go) begin
          state_next = adlq_pkg::ST_DIVIDE;
        end
      end
      adlq_pkg::ST_DIVIDE: begin
        if (div_rsp.done) begin
          state_next = adlq_pkg::ST_WALK;
        end
      end
      adlq_pkg::ST_WALK: begin
        if (walk_done) begin
          state_next = adlq_pkg::ST_EMIT;
        end
      end
      adlq_pkg::ST_EMIT: begin
        if (out_free) begin
          state_next = adlq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = adlq_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    q_pop            = (state == adlq_pkg::ST_IDLE) && q_valid && out_free;
    tick_go          = q_pop && (q_data.op == adlq_pkg::OP_TICK) && (queued != '0);
    emit_now         = q_pop && !tick_go;
    emit_late        = (state == adlq_pkg::ST_EMIT) && out_free;
    walk_done        = (state == adlq_pkg::ST_WALK) && ((samples == '0) || (queued == '0));
    div_req.start    = tick_go;
    div_req.dividend = acc_sum;

    imm_rd    = '0;
    imm_irq   = irq_pend;
    imm_start = 1'b0;
    unique case (q_data.op)
      adlq_pkg::OP_RD_LEN: begin
        imm_rd = DATA_W'(cur_len);
      end
      adlq_pkg::OP_RD_STATUS: begin
        if (queued == adlq_pkg::QUEUED_FULL) begin
          imm_rd = imm_rd | adlq_pkg::STAT_FULL;
        end
        if (queued != '0) begin
          imm_rd = imm_rd | adlq_pkg::STAT_BUSY;
        end
      end
      adlq_pkg::OP_WR_LEN: begin
        imm_start = (queued != adlq_pkg::QUEUED_FULL);
      end
      adlq_pkg::OP_WR_STATUS: begin
        imm_irq = 1'b0;
      end
      default: begin
        imm_rd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= adlq_pkg::ST_IDLE;
      acc       <= '0;
      cur_len   <= '0;
      nxt_len   <= '0;
      queued    <= '0;
      dram_addr <= '0;
      irq_pend  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;

      if (emit_now || emit_late) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end

      if (q_pop) begin
        unique case (q_data.op)
          adlq_pkg::OP_WR_ADDR: begin
            dram_addr <= q_data.data[ADDR_W-1:0];
          end
          adlq_pkg::OP_WR_LEN: begin
            if (queued != adlq_pkg::QUEUED_FULL) begin
              if (queued == '0) begin
                cur_len <= q_data.data[LEN_W-1:0];
              end else begin
                nxt_len <= q_data.data[LEN_W-1:0];
              end
              queued <= queued + 2'd1;
            end
          end
          adlq_pkg::OP_WR_STATUS: begin
            irq_pend <= 1'b0;
          end
          adlq_pkg::OP_TICK: begin
            if (queued != '0) begin
              acc <= acc_sum;
            end
          end
          default: begin
            irq_pend <= irq_pend;
          end
        endcase
      end

      if (walk_done) begin
        acc <= (queued != '0) ? ACC_W'(rem) : '0;
      end else if (state == adlq_pkg::ST_WALK) begin
        if (!short_run) begin
          // Current buffer ends: promote the next one or go empty.
          queued <= queued - 2'd1;
          if (queued != 2'd1) begin
            irq_pend <= 1'b1;
            cur_len  <= nxt_len;
          end else begin
            cur_len <= '0;
          end
        end else begin
          cur_len <= cur_len - samples[LEN_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == adlq_pkg::ST_DIVIDE) && div_rsp.done) begin
      samples <= div_rsp.quotient;
      rem     <= div_rsp.remainder;
    end else if ((state == adlq_pkg::ST_WALK) && !walk_done) begin
      samples <= short_run ? '0 : (samples - ACC_W'(need));
    end

    if (emit_now) begin
      out_rd    <= imm_rd;
      out_irq   <= imm_irq;
      out_start <= imm_start;
      out_addr  <= imm_start ? dram_addr : '0;
      out_len   <= imm_start ? q_data.data[LEN_W-1:0] : '0;
    end else if (emit_late) begin
      out_rd    <= '0;
      out_irq   <= irq_pend;
      out_start <= 1'b0;
      out_addr  <= '0;
      out_len   <= '0;
    end
  end

endmodule

// File: hdl/audio_dma_length_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_dma_length_queue_top
// Audio DMA register block with a two-entry buffer length queue.
// ----------------------------------------------------------------------------
// Channels: req carries one item per register read, register write or tick;
// rsp returns exactly one item per request: read data, interrupt level and,
// for an accepted length write, a DMA start with address and length.
// A decode stage fills a two-entry queue; the execute stage drains it.
// Reads, writes and ticks with nothing queued pass through the queue and the
// output register and sustain one item per cycle while the receiver is ready.
// A tick with a buffer queued divides the cycle accumulator by the sample
// period with a reciprocal multiply (four partial products and a remainder
// step), then walks at most two buffer ends, one per cycle.
// While the receiver stalls, the finished response waits in the output
// register and the queue keeps taking requests until it is full.
// Reset (synchronous, active high) empties the queue, clears all lengths,
// the latched address, the accumulator and the interrupt.
// ----------------------------------------------------------------------------
module audio_dma_length_queue_top #(
  parameter int CYCLES_PER_SAMPLE = adlq_pkg::CYCLES_PER_SAMPLE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  adlq_req_if.sink    req,
  adlq_rsp_if.source  rsp
);

  logic                          q_push;
  adlq_pkg::entry_t              q_in;
  logic                          q_full;
  logic                          q_pop;
  logic                          q_valid;
  adlq_pkg::entry_t              q_out;
  logic [adlq_pkg::QCNT_W-1:0]   q_count;
  adlq_pkg::div_req_t            div_req;
  adlq_pkg::div_rsp_t            div_rsp;

  adlq_front u_front (
    .req   (req),
    .full  (q_full),
    .push  (q_push),
    .entry (q_in)
  );

  adlq_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_out),
    .count     (q_count)
  );

  adlq_div #(
    .DIVISOR (CYCLES_PER_SAMPLE)
  ) u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  adlq_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_out),
    .q_pop   (q_pop),
    .div_req (div_req),
    .div_rsp (div_rsp),
    .rsp     (rsp)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= adlq_pkg::QCNT_W'(adlq_pkg::QUEUE_DEPTH))
    else $error("length queue count beyond depth");

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider restarted while busy");

  a_start_aligned: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.dma_start |-> (rsp.dma_length[2:0] == 3'd0) &&
                                   (rsp.dma_address[2:0] == 3'd0))
    else $error("DMA start with unaligned address or length");

  a_no_start_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.dma_start |-> (rsp.dma_length == '0) && (rsp.dma_address == '0))
    else $error("DMA fields set without a start");

  a_read_bits: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.read_data[29:18] == '0))
    else $error("read data outside length and status bits");

endmodule

// File: bench/audio_dma_length_queue_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_dma_length_queue_top_tb
// Self-checking bench for the audio DMA length queue. Request items are
// driven with random gaps; responses are taken with random and long stalls.
// A cycle-free predictor of the register file, length queue and sample
// countdown works out the reply to each accepted item. Every reply is
// compared field by field against the oldest expected one.
// ----------------------------------------------------------------------------
module audio_dma_length_queue_top_tb;
  import adlq_pkg::*;

  localparam int          SAMPLE_PERIOD = CYCLES_PER_SAMPLE_DEF;
  localparam int          RANDOM_ITEMS  = 550;
  localparam int          DRAIN_CYCLES  = 80;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          MAX_REPORTS   = 10;
  localparam logic [1:0]  CMD_SPARE     = 2'd3;
  localparam logic [2:0]  REG_CONTROL   = 3'd2;
  localparam logic [2:0]  REG_DACRATE   = 3'd4;
  localparam logic [2:0]  REG_BITRATE   = 3'd5;
  localparam logic [2:0]  REG_SPARE7    = 3'd7;
  localparam logic [31:0] ALL_ONES      = 32'hffff_ffff;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              irq;
    logic              dma_start;
    logic [ADDR_W-1:0] dma_address;
    logic [LEN_W-1:0]  dma_length;
  } dma_reply_t;

  logic clk = 1'b0;
  logic rst;

  adlq_req_if req ();
  adlq_rsp_if rsp ();

  audio_dma_length_queue_top #(
    .CYCLES_PER_SAMPLE(SAMPLE_PERIOD)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted block state
  logic [ACC_W-1:0]  pb_accum;
  logic [LEN_W-1:0]  pb_cur_len;
  logic [LEN_W-1:0]  pb_next_len;
  logic [1:0]        pb_queued;
  logic [ADDR_W-1:0] pb_dram_addr;
  logic              pb_irq;

  dma_reply_t  pending_replies[$];
  int          failures;
  int          items_sent;
  bit          sender_gaps;
  bit          receiver_stalls;
  int          hold_request;
  int          stall_left;

  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 99) < 88) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Consume elapsed cycles: whole samples count down the current buffer,
  // crossing into the next one (with interrupt) when it runs out.
  function automatic void advance_playback(logic [31:0] cycles);
    logic [63:0] total;
    logic [63:0] samples;
    logic [63:0] leftover;
    logic [63:0] need;
    if (pb_queued == 2'd0) return;
    total    = 64'(pb_accum) + 64'(cycles);
    pb_accum = total[ACC_W-1:0];
    samples  = 64'(pb_accum) / 64'(SAMPLE_PERIOD);
    leftover = 64'(pb_accum) % 64'(SAMPLE_PERIOD);
    while (samples != 0 && pb_queued != 2'd0) begin
      need = (pb_cur_len != '0) ? 64'(pb_cur_len) : 64'(LEN_SPAN);
      if (samples < need) begin
        pb_cur_len = pb_cur_len - samples[LEN_W-1:0];
        samples    = 0;
      end else begin
        samples    = samples - need;
        pb_cur_len = '0;
        pb_queued  = pb_queued - 2'd1;
        if (pb_queued != 2'd0) begin
          pb_irq     = 1'b1;
          pb_cur_len = pb_next_len;
        end
      end
    end
    pb_accum = (pb_queued != 2'd0) ? leftover[ACC_W-1:0] : '0;
  endfunction

  function automatic dma_reply_t predict_reply(logic [1:0] op_cmd, logic [2:0] op_reg,
                                               logic [31:0] op_data, logic [31:0] op_cycles);
    dma_reply_t  reply;
    logic [31:0] len_word;
    reply = '0;
    case (op_cmd)
      CMD_READ: begin
        if (op_reg == REG_LEN) begin
          reply.read_data = 32'(pb_cur_len);
        end else if (op_reg == REG_STATUS) begin
          if (pb_queued == QUEUED_FULL) reply.read_data = reply.read_data | STAT_FULL;
          if (pb_queued != 2'd0) reply.read_data = reply.read_data | STAT_BUSY;
        end
      end
      CMD_WRITE: begin
        if (op_reg == REG_ADDR) begin
          pb_dram_addr = ADDR_W'(op_data & ADDR_MASK);
        end else if (op_reg == REG_LEN) begin
          len_word = op_data & LEN_MASK;
          if (pb_queued < QUEUED_FULL) begin
            if (pb_queued == 2'd0) pb_cur_len = len_word[LEN_W-1:0];
            else pb_next_len = len_word[LEN_W-1:0];
            pb_queued         = pb_queued + 2'd1;
            reply.dma_start   = 1'b1;
            reply.dma_address = pb_dram_addr;
            reply.dma_length  = len_word[LEN_W-1:0];
          end
        end else if (op_reg == REG_STATUS) begin
          pb_irq = 1'b0;
        end
      end
      CMD_TICK: advance_playback(op_cycles);
      CMD_SPARE: ;
    endcase
    reply.irq = pb_irq;
    return reply;
  endfunction

  // Drive one item at a falling edge and hold it until accepted.
  task automatic send_request(input logic [1:0] op_cmd, input logic [2:0] op_reg,
                              input logic [31:0] op_data, input logic [31:0] op_cycles);
    int unsigned gap;
    gap = (sender_gaps && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.valid       <= 1'b1;
    req.cmd         <= op_cmd;
    req.reg_index   <= op_reg;
    req.write_data  <= op_data;
    req.tick_cycles <= op_cycles;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    pending_replies.push_back(predict_reply(op_cmd, op_reg, op_data, op_cycles));
    items_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    req.valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  task automatic note_failure(input string what, input dma_reply_t want,
                              input dma_reply_t got);
    failures++;
    if (failures <= MAX_REPORTS)
      $display("%0t %s: exp rd=%h irq=%b start=%b addr=%h len=%h / got rd=%h irq=%b start=%b addr=%h len=%h",
               $realtime, what, want.read_data, want.irq, want.dma_start,
               want.dma_address, want.dma_length, got.read_data, got.irq,
               got.dma_start, got.dma_address, got.dma_length);
  endtask

  // Response checker
  always @(posedge clk) begin : check_reply
    dma_reply_t got;
    dma_reply_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      got = {rsp.read_data, rsp.irq, rsp.dma_start, rsp.dma_address, rsp.dma_length};
      if (pending_replies.size() == 0) begin
        note_failure("unexpected reply", '0, got);
      end else begin
        want = pending_replies.pop_front();
        if (got.read_data !== want.read_data || got.irq !== want.irq ||
            got.dma_start !== want.dma_start || got.dma_address !== want.dma_address ||
            got.dma_length !== want.dma_length)
          note_failure("reply mismatch", want, got);
      end
    end
  end

  // Receiver: random stalls, plus long hold-offs on request
  initial begin
    rsp.ready  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        stall_left   = hold_request;
        hold_request = 0;
      end
      if (stall_left > 0) begin
        rsp.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp.ready <= 1'b1;
        if (receiver_stalls && $urandom_range(0, 99) < 25) stall_left = pick_gap();
      end
    end
  end

  function automatic logic [31:0] pick_tick_cycles();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return $urandom_range(0, 4 * SAMPLE_PERIOD);
    if (r < 85) return $urandom_range(0, 200 * SAMPLE_PERIOD);
    return $urandom;
  endfunction

  // Length word: mostly short buffers, some anywhere in range, a few zero.
  function automatic logic [31:0] pick_length_word();
    int unsigned r;
    logic [31:0] samples;
    r = $urandom_range(0, 99);
    if (r < 70) samples = $urandom_range(1, 16);
    else if (r < 92) samples = $urandom_range(0, 32'h7fff);
    else samples = 0;
    return ($urandom & ~LEN_MASK) | (LEN_MASK & (samples << 3));
  endfunction

  task automatic send_random_op();
    int unsigned pick;
    int unsigned r;
    logic [2:0]  idx;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      send_request(CMD_TICK, 3'($urandom), $urandom, pick_tick_cycles());
    end else if (pick < 45) begin
      send_request(CMD_WRITE, REG_LEN, pick_length_word(), $urandom);
    end else if (pick < 55) begin
      send_request(CMD_WRITE, REG_ADDR, $urandom, $urandom);
    end else if (pick < 75) begin
      r   = $urandom_range(0, 99);
      idx = (r < 45) ? REG_STATUS : (r < 80) ? REG_LEN : 3'($urandom);
      send_request(CMD_READ, idx, $urandom, $urandom);
    end else if (pick < 85) begin
      send_request(CMD_WRITE, REG_STATUS, $urandom, $urandom);
    end else begin
      send_request(2'($urandom), 3'($urandom), $urandom, $urandom);
    end
  endtask

  task automatic test_register_map();
    send_request(CMD_TICK, REG_ADDR, '0, ALL_ONES);      // tick with nothing queued
    send_request(CMD_WRITE, REG_ADDR, ALL_ONES, '0);
    send_request(CMD_WRITE, REG_CONTROL, ALL_ONES, '0);
    send_request(CMD_WRITE, REG_SPARE7, ALL_ONES, ALL_ONES);
    send_request(CMD_SPARE, REG_SPARE7, ALL_ONES, ALL_ONES);
    for (int i = 0; i < 8; i++) send_request(CMD_READ, 3'(i), '0, '0);
  endtask

  task automatic test_queue_full();
    send_request(CMD_WRITE, REG_LEN, ALL_ONES, '0);
    send_request(CMD_WRITE, REG_LEN, 32'h0000_0008, '0);
    send_request(CMD_WRITE, REG_LEN, ALL_ONES, '0);     // refused: queue full
    send_request(CMD_READ, REG_STATUS, '0, '0);
  endtask

  // One long tick runs out the first buffer (irq) and then the last one.
  task automatic test_buffer_handover();
    send_request(CMD_TICK, REG_LEN, '0, ALL_ONES);
    send_request(CMD_READ, REG_STATUS, '0, '0);
    send_request(CMD_WRITE, REG_STATUS, ALL_ONES, '0);
  endtask

  task automatic test_zero_length_wrap();
    send_request(CMD_WRITE, REG_ADDR, '0, '0);
    send_request(CMD_WRITE, REG_LEN, '0, '0);
    send_request(CMD_TICK, REG_ADDR, '0, 32'(SAMPLE_PERIOD));
    send_request(CMD_READ, REG_LEN, '0, '0);
    send_request(CMD_TICK, REG_ADDR, '0, ALL_ONES);
  endtask

  // Receiver holds off while the sender keeps offering items.
  task automatic test_backpressure();
    sender_gaps  = 1'b0;
    hold_request = HOLD_CYCLES;
    send_request(CMD_WRITE, REG_ADDR, $urandom, '0);
    repeat (3) send_request(CMD_WRITE, REG_LEN, pick_length_word(), '0);
    send_request(CMD_READ, REG_STATUS, '0, '0);
    send_request(CMD_TICK, REG_ADDR, '0, 32'(3 * SAMPLE_PERIOD));
    send_request(CMD_READ, REG_LEN, '0, '0);
    send_request(CMD_WRITE, REG_STATUS, '0, '0);
    send_request(CMD_READ, REG_STATUS, '0, '0);
    send_request(CMD_TICK, REG_ADDR, '0, ALL_ONES);
    sender_gaps = 1'b1;
  endtask

  task automatic test_random_traffic();
    int target;
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      if ($urandom_range(0, 59) == 0) begin
        sender_gaps     = ($urandom_range(0, 3) != 0);
        receiver_stalls = ($urandom_range(0, 3) != 0);
      end
      send_random_op();
    end
  endtask

  initial begin
    rst             = 1'b1;
    req.valid       = 1'b0;
    req.cmd         = CMD_READ;
    req.reg_index   = REG_ADDR;
    req.write_data  = '0;
    req.tick_cycles = '0;
    pb_accum        = '0;
    pb_cur_len      = '0;
    pb_next_len     = '0;
    pb_queued       = '0;
    pb_dram_addr    = '0;
    pb_irq          = 1'b0;
    failures        = 0;
    items_sent      = 0;
    hold_request    = 0;
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_register_map();
    test_queue_full();
    test_buffer_handover();
    test_zero_length_wrap();
    test_backpressure();
    test_random_traffic();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("audio_dma_length_queue_top_tb passed");
    end else begin
      $display("audio_dma_length_queue_top_tb failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("audio_dma_length_queue_top_tb failed");
    $finish;
  end

endmodule

// File: filelist.f
hdl/adlq_pkg.sv
hdl/adlq_req_if.sv
hdl/adlq_rsp_if.sv
hdl/adlq_front.sv
hdl/adlq_fifo.sv
hdl/adlq_div.sv
hdl/adlq_back.sv
hdl/audio_dma_length_queue_top.sv
bench/audio_dma_length_queue_top_tb.sv
